@@ src/bounded_deque_macros.svh @@
// ----------------------------------------------------------------------------
// bounded_deque_macros.svh
// Assertion macros used by the bounded deque port checker, bdq_chk.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_MACROS_SVH
`define BOUNDED_DEQUE_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define BDQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BDQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/bdq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and codes for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam logic [1:0] ACT_PUSH_FRONT = 2'd0;
  localparam logic [1:0] ACT_PUSH_BACK  = 2'd1;
  localparam logic [1:0] ACT_POP_FRONT  = 2'd2;
  localparam logic [1:0] ACT_POP_BACK   = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIN
  } bdq_state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic mem_wr;
    logic mem_rd;
    logic load_out;
  } bdq_cmd_t;

  typedef struct packed {
    logic is_push;
    logic op_ok;
  } bdq_sts_t;

endpackage
`default_nettype wire

@@ src/bdq_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_if
// Request and result channels of the bounded deque.
// ----------------------------------------------------------------------------
interface bdq_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic signed [31:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
  modport mon    (input valid, input ready, input action, input value);
endinterface

interface bdq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] popped;
  logic        [1:0]  status;
  logic        [4:0]  count;
  logic               is_empty;

  modport source (output valid, output popped, output status, output count,
                  output is_empty, input ready);
  modport sink   (input valid, input popped, input status, input count,
                  input is_empty, output ready);
  modport mon    (input valid, input ready, input popped, input status,
                  input count, input is_empty);
endinterface
`default_nettype wire

@@ src/bdq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: accept a request, execute it on the ring, hand off the result.
// ----------------------------------------------------------------------------
module bdq_ctrl
  import bdq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire bdq_sts_t sts,
  output bdq_cmd_t      cmd
);

  bdq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: state_nxt = ST_FIN;
      ST_FIN: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        cmd.mem_wr = sts.op_ok && sts.is_push;
        cmd.mem_rd = sts.op_ok && !sts.is_push;
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

@@ src/bdq_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_dp
// Ring storage, head and fill registers, and the result register.
// ----------------------------------------------------------------------------
module bdq_dp
  import bdq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bdq_cmd_t           cmd,
  output bdq_sts_t                sts,
  input  wire logic        [1:0]  in_action,
  input  wire logic signed [31:0] in_value,
  output logic signed      [31:0] out_popped,
  output logic             [1:0]  out_status,
  output logic             [4:0]  out_count,
  output logic                    out_is_empty
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [SW-1:0] CAP_S  = SW'(CAPACITY);

  logic signed [31:0] mem [CAPACITY];

  logic        [1:0]  action_r;
  logic signed [31:0] value_r;
  logic        [AW-1:0] head_r, head_nxt;
  logic        [CW-1:0] held_r, held_nxt;
  logic signed [31:0] rdata_r;
  logic               pop_ok_r;
  logic        [1:0]  status_r;

  logic               is_push, full, empty, op_ok;
  logic        [CW-1:0] offset;
  logic        [SW-1:0] sum, wrapped;
  logic        [AW-1:0] back_idx, head_dec, head_inc, addr;
  logic        [CW+4:0] held_ext;

  assign is_push = !action_r[1];
  assign full    = held_r == CAP_C;
  assign empty   = held_r == '0;
  assign op_ok   = is_push ? !full : !empty;

  assign offset   = is_push ? held_r : held_r - CW'(1);
  assign sum      = SW'(head_r) + SW'(offset);
  assign wrapped  = (sum >= CAP_S) ? sum - CAP_S : sum;
  assign back_idx = wrapped[AW-1:0];
  assign head_dec = (head_r == '0) ? LAST_A : head_r - AW'(1);
  assign head_inc = (head_r == LAST_A) ? '0 : head_r + AW'(1);

  always_comb begin
    addr     = head_r;
    head_nxt = head_r;
    case (action_r)
      ACT_PUSH_FRONT: begin
        addr     = head_dec;
        head_nxt = head_dec;
      end
      ACT_PUSH_BACK:  addr = back_idx;
      ACT_POP_FRONT: begin
        addr     = head_r;
        head_nxt = head_inc;
      end
      ACT_POP_BACK:   addr = back_idx;
      default:        addr = head_r;
    endcase
  end

  assign held_nxt = is_push ? held_r + CW'(1) : held_r - CW'(1);

  assign sts.is_push = is_push;
  assign sts.op_ok   = op_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      held_r <= '0;
    end else if (cmd.exec && op_ok) begin
      head_r <= head_nxt;
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[addr] <= value_r;
    if (cmd.mem_rd) rdata_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      action_r <= in_action;
      value_r  <= in_value;
    end
    if (cmd.exec) begin
      pop_ok_r <= op_ok && !is_push;
      status_r <= op_ok ? STATUS_OK : (is_push ? STATUS_FULL : STATUS_EMPTY);
    end
  end

  // count port keeps the low five bits of the fill level
  assign held_ext = (CW + 5)'(held_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_popped   <= pop_ok_r ? rdata_r : '1;
      out_status   <= status_r;
      out_count    <= held_ext[4:0];
      out_is_empty <= empty;
    end
  end

endmodule
`default_nettype wire

@@ src/bounded_deque.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque
// Bounded double-ended queue of signed 32-bit words in a ring buffer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      word
//  in_ch     in   valid/ready    action, value
//  out_ch    out  valid/ready    popped, status, count, is_empty
//
//  Each request passes through three steps: accept, ring access (one memory
//  port, registered read), then load of the result register.
//  A new request is accepted while a finished result waits on out_ch.
//  A held result stalls the sequencer only in its final step.
//  Synchronous reset empties the queue; ring contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_deque
  import bdq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bdq_in_if.sink    in_ch,
  bdq_out_if.source out_ch
);

  bdq_cmd_t cmd;
  bdq_sts_t sts;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bdq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_action    (in_ch.action),
    .in_value     (in_ch.value),
    .out_popped   (out_ch.popped),
    .out_status   (out_ch.status),
    .out_count    (out_ch.count),
    .out_is_empty (out_ch.is_empty)
  );

endmodule
`default_nettype wire

@@ src/bdq_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_chk
// Port-level checks on the bounded deque result channel.
// ----------------------------------------------------------------------------
`include "bounded_deque_macros.svh"

module bdq_chk
  import bdq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] out_popped,
  input wire logic        [1:0]  out_status,
  input wire logic        [4:0]  out_count,
  input wire logic               out_is_empty
);

  localparam logic [4:0] CAP_5 = 5'(CAPACITY);

  `BDQ_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_valid, "result valid after reset")
  `BDQ_ASSERT(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_popped), "result word dropped while stalled")
  `BDQ_ASSERT(a_full, clk, rst_n, out_valid && out_status == STATUS_FULL |-> out_count == CAP_5 && out_popped == '1, "full refusal with wrong count or word")
  `BDQ_ASSERT(a_empty, clk, rst_n, out_valid && out_status == STATUS_EMPTY |-> out_is_empty && out_popped == '1, "empty pop not reported empty")

endmodule

bind bounded_deque bdq_chk #(
  .CAPACITY (CAPACITY)
) u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_popped   (out_ch.popped),
  .out_status   (out_ch.status),
  .out_count    (out_ch.count),
  .out_is_empty (out_ch.is_empty)
);
`default_nettype wire

@@ verif/deque_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_result_checker
// Watches the request and result channels of the bounded deque. It keeps its
// own copy of the ring, head and count, works out the result of every
// accepted request and compares each returned word with the oldest one due.
// ----------------------------------------------------------------------------
module deque_result_checker
  import bdq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bdq_in_if.mon     in_mon,
  bdq_out_if.mon    out_mon,
  output int        error_count,
  output int        pending_count
);

  typedef struct packed {
    logic signed [31:0] popped;
    logic        [1:0]  status;
    logic        [4:0]  count;
    logic               is_empty;
  } deque_result_t;

  logic signed [31:0] ring_copy [CAPACITY];
  int                 front_pos = 0;
  int                 held      = 0;
  deque_result_t      due_results [$];

  initial begin
    error_count   = 0;
    pending_count = 0;
  end

  task automatic report_mismatch(string what);
    $display("ERROR %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic deque_result_t apply_request(logic [1:0] action,
                                                  logic signed [31:0] word);
    deque_result_t r;
    r.popped = -32'sd1;
    r.status = STATUS_OK;
    case (action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (held >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else if (action == ACT_PUSH_FRONT) begin
          front_pos = (front_pos + CAPACITY - 1) % CAPACITY;
          ring_copy[front_pos] = word;
          held++;
        end else begin
          ring_copy[(front_pos + held) % CAPACITY] = word;
          held++;
        end
      end
      default: begin
        if (held == 0) begin
          r.status = STATUS_EMPTY;
        end else if (action == ACT_POP_FRONT) begin
          r.popped  = ring_copy[front_pos];
          front_pos = (front_pos + 1) % CAPACITY;
          held--;
        end else begin
          r.popped = ring_copy[(front_pos + held - 1) % CAPACITY];
          held--;
        end
      end
    endcase
    r.count    = 5'(held);
    r.is_empty = (held == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    deque_result_t got, want;
    if (!rst_n) begin
      due_results.delete();
      front_pos = 0;
      held      = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{popped: out_mon.popped, status: out_mon.status,
                count: out_mon.count, is_empty: out_mon.is_empty};
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result word with none due: popped %0d status %0d",
                                    got.popped, got.status));
        end else begin
          want = due_results.pop_front();
          if (got.popped !== want.popped)
            report_mismatch($sformatf("popped %0d, want %0d", got.popped, want.popped));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.count !== want.count)
            report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
          if (got.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty %0b, want %0b", got.is_empty,
                                      want.is_empty));
        end
      end
      if (in_mon.valid && in_mon.ready)
        due_results.push_back(apply_request(in_mon.action, in_mon.value));
    end
    pending_count = due_results.size();
  end

endmodule

@@ verif/tb_bounded_deque.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_deque
// Drives push and pop requests into the bounded deque: a directed run over
// empty pops, single-entry pops, extreme words and a full queue, then random
// runs that swing between filling and draining, under varied idling on both
// channels. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_bounded_deque;
  import bdq_pkg::*;

  localparam int DEPTH = 16;

  logic clk;
  logic rst_n;
  int   error_count;
  int   pending_count;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;

  bdq_in_if  in_ch ();
  bdq_out_if out_ch ();

  bounded_deque #(.CAPACITY(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deque_result_checker #(.CAPACITY(DEPTH)) result_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_request(logic [1:0] action, logic signed [31:0] word);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= action;
    in_ch.value  <= word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // hold off until every result word is back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic run_phase(int items, int idle_pct, int stall);
    int                 push_pct;
    int                 seg_left;
    logic        [1:0]  act;
    logic signed [31:0] w;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    push_pct      = 50;
    seg_left      = 0;
    for (int i = 0; i < items; i++) begin
      // alternate fill-heavy and drain-heavy stretches to hit full and empty
      if (seg_left == 0) begin
        seg_left = $urandom_range(40, 8);
        case ($urandom_range(2))
          0:       push_pct = 80;
          1:       push_pct = 50;
          default: push_pct = 20;
        endcase
      end
      seg_left--;
      if ($urandom_range(99) < push_pct)
        act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
      else
        act = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
      case ($urandom_range(15))
        0:       w = 32'sh7FFFFFFF;
        1:       w = 32'sh80000000;
        2:       w = 32'sd0;
        3:       w = -32'sd1;
        default: w = $urandom;
      endcase
      send_request(act, w);
    end
    drain_results();
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_PUSH_FRONT;
    in_ch.value  = 32'sd0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty pops, single-entry pops at each end, extreme words
    send_request(ACT_POP_FRONT, 32'sd5);
    send_request(ACT_POP_BACK, -32'sd1);
    send_request(ACT_PUSH_BACK, 32'sh7FFFFFFF);
    send_request(ACT_POP_FRONT, 32'sd0);
    send_request(ACT_PUSH_FRONT, 32'sh80000000);
    send_request(ACT_PUSH_BACK, 32'sh55555555);
    send_request(ACT_POP_BACK, 32'sd0);
    send_request(ACT_POP_BACK, 32'sd0);
    // fill from both ends, then push into a full queue
    for (int k = 0; k < DEPTH; k++)
      send_request(k[0] ? ACT_PUSH_BACK : ACT_PUSH_FRONT, $urandom);
    send_request(ACT_PUSH_FRONT, 32'sd1);
    send_request(ACT_PUSH_BACK, 32'sd2);
    drain_results();

    run_phase(350, 0, 0);
    run_phase(350, 72, 0);
    run_phase(350, 0, 72);
    run_phase(350, 15, 15);
    run_phase(350, 0, 0);

    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("tb_bounded_deque passed");
    else
      $display("tb_bounded_deque failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_bounded_deque failed");
    $finish;
  end

endmodule
